// ----- sv/mpm_pkg.sv -----
// shared types and constants for the multi-period meter
// no dependencies; used by mpm_core, mpm_out_buf and multi_period_meter
package mpm_pkg;

  // configuration port
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 32;

  localparam logic [CFG_INDEX_W-1:0] REG_PERIODS = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_TIMEOUT = 1'b1;

  localparam logic [15:0] PERIODS_RESET = 16'd100;
  localparam logic [31:0] TIMEOUT_RESET = 32'd5000000;

  // measurement phase
  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_PRE_LOW   = 3'd1,
    PH_PRE_HIGH  = 3'd2,
    PH_MEAS_LOW  = 3'd3,
    PH_MEAS_HIGH = 3'd4
  } phase_t;

  // function codes of an input transaction
  localparam logic FUNC_TICK  = 1'b0;
  localparam logic FUNC_START = 1'b1;

  typedef struct packed {
    logic func;
    logic pin_level;
  } in_t;

  typedef struct packed {
    logic [31:0] period_count;
    logic        no_signal;
  } out_t;

  // result handed from the core to the output buffer
  typedef struct packed {
    logic valid;
    out_t data;
  } result_t;

endpackage

// ----- sv/mpm_core.sv -----
// measurement state machine: phase, tick counter, period count, config registers
// depends on mpm_pkg
module mpm_core #(
  parameter int COUNTER_WIDTH = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               accept,
  input  mpm_pkg::in_t                       in_data,
  input  logic                               cfg_we,
  input  logic [mpm_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [mpm_pkg::CFG_DATA_W-1:0]     cfg_data,
  output mpm_pkg::result_t                   result
);

  localparam int CMP_W = (COUNTER_WIDTH > 32) ? COUNTER_WIDTH : 32;
  localparam logic [COUNTER_WIDTH-1:0] CNT_MAX = {COUNTER_WIDTH{1'b1}};

  mpm_pkg::phase_t            phase, phase_next;
  logic [COUNTER_WIDTH-1:0]   tick_counter, tick_counter_next;
  logic [15:0]                periods_seen, periods_seen_next;
  logic [15:0]                periods_to_measure;
  logic [31:0]                timeout_ticks;

  logic [COUNTER_WIDTH-1:0]   cnt_inc;
  logic [CMP_W-1:0]           cnt_ext;
  logic [15:0]                periods_inc;
  logic                       want;
  logic                       hit;
  logic                       timed_out;
  logic                       done;

  // saturating counter increment and shared compares
  always_comb begin
    cnt_inc     = (tick_counter != CNT_MAX) ? tick_counter + 1'b1 : tick_counter;
    cnt_ext     = CMP_W'(cnt_inc);
    periods_inc = (periods_seen != 16'hFFFF) ? periods_seen + 16'd1 : periods_seen;
    want        = (phase == mpm_pkg::PH_PRE_HIGH) || (phase == mpm_pkg::PH_MEAS_HIGH);
    hit         = (in_data.pin_level == want);
    timed_out   = (cnt_ext > CMP_W'(timeout_ticks)) || (cnt_inc == CNT_MAX);
    done        = (periods_inc >= periods_to_measure);
  end

  // next phase
  always_comb begin
    phase_next = phase;
    if (accept) begin
      if (in_data.func == mpm_pkg::FUNC_START) begin
        phase_next = (periods_to_measure == 16'd0) ? mpm_pkg::PH_IDLE : mpm_pkg::PH_PRE_LOW;
      end else begin
        case (phase)
          mpm_pkg::PH_PRE_LOW: begin
            if (hit) phase_next = mpm_pkg::PH_PRE_HIGH;
            else if (timed_out) phase_next = mpm_pkg::PH_IDLE;
          end
          mpm_pkg::PH_PRE_HIGH: begin
            if (hit) phase_next = mpm_pkg::PH_MEAS_LOW;
            else if (timed_out) phase_next = mpm_pkg::PH_IDLE;
          end
          mpm_pkg::PH_MEAS_LOW: begin
            if (hit) phase_next = mpm_pkg::PH_MEAS_HIGH;
            else if (timed_out) phase_next = mpm_pkg::PH_IDLE;
          end
          mpm_pkg::PH_MEAS_HIGH: begin
            if (hit) phase_next = done ? mpm_pkg::PH_IDLE : mpm_pkg::PH_MEAS_LOW;
            else if (timed_out) phase_next = mpm_pkg::PH_IDLE;
          end
          default: phase_next = mpm_pkg::PH_IDLE;
        endcase
      end
    end
  end

  // counters and result
  always_comb begin
    tick_counter_next = tick_counter;
    periods_seen_next = periods_seen;
    result            = '0;
    if (accept) begin
      if (in_data.func == mpm_pkg::FUNC_START) begin
        tick_counter_next = '0;
        periods_seen_next = '0;
        result.valid      = (periods_to_measure == 16'd0);
      end else begin
        case (phase)
          mpm_pkg::PH_PRE_LOW, mpm_pkg::PH_PRE_HIGH: begin
            tick_counter_next = hit ? '0 : cnt_inc;
            if (!hit && timed_out) begin
              result.valid          = 1'b1;
              result.data.no_signal = 1'b1;
            end
          end
          mpm_pkg::PH_MEAS_LOW: begin
            tick_counter_next = cnt_inc;
            if (!hit && timed_out) begin
              result.valid          = 1'b1;
              result.data.no_signal = 1'b1;
            end
          end
          mpm_pkg::PH_MEAS_HIGH: begin
            tick_counter_next = cnt_inc;
            if (hit) begin
              periods_seen_next = periods_inc;
              if (done) begin
                result.valid             = 1'b1;
                result.data.period_count = cnt_ext[31:0];
              end
            end else if (timed_out) begin
              result.valid          = 1'b1;
              result.data.no_signal = 1'b1;
            end
          end
          default: ;
        endcase
      end
    end
  end

  // state and configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase              <= mpm_pkg::PH_IDLE;
      tick_counter       <= '0;
      periods_seen       <= '0;
      periods_to_measure <= mpm_pkg::PERIODS_RESET;
      timeout_ticks      <= mpm_pkg::TIMEOUT_RESET;
    end else begin
      phase        <= phase_next;
      tick_counter <= tick_counter_next;
      periods_seen <= periods_seen_next;
      if (cfg_we && cfg_index == mpm_pkg::REG_PERIODS) begin
        periods_to_measure <= cfg_data[15:0];
      end
      if (cfg_we && cfg_index == mpm_pkg::REG_TIMEOUT) begin
        timeout_ticks <= cfg_data[31:0];
      end
    end
  end

endmodule

// ----- sv/mpm_out_buf.sv -----
// two-entry output buffer: result register plus skid register
// depends on mpm_pkg
module mpm_out_buf (
  input  logic              clk,
  input  logic              rst,
  input  mpm_pkg::result_t  result,
  output logic              full,
  output logic              out_valid,
  input  logic              out_stall,
  output mpm_pkg::out_t     out_data
);

  logic          head_valid;
  logic          skid_valid;
  mpm_pkg::out_t head;
  mpm_pkg::out_t skid;
  logic          pop;

  assign pop       = head_valid && !out_stall;
  assign out_valid = head_valid;
  assign out_data  = head;
  assign full      = skid_valid;

  // valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!head_valid || pop) begin
      head_valid <= skid_valid || result.valid;
      skid_valid <= skid_valid && result.valid;
    end else if (result.valid) begin
      skid_valid <= 1'b1;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (!head_valid || pop) begin
      if (skid_valid) begin
        head <= skid;
        if (result.valid) skid <= result.data;
      end else begin
        head <= result.data;
      end
    end else if (result.valid) begin
      skid <= result.data;
    end
  end

endmodule

// ----- sv/multi_period_meter.sv -----
// top level of the multi-period meter
// depends on mpm_pkg, mpm_core and mpm_out_buf
//
// channel  direction  payload                        handshake
// in       input      in_data  {func, pin_level}     in_valid / in_stall
// out      output     out_data {period_count, no_signal} out_valid / out_stall
// cfg      input      cfg_index, cfg_data            cfg_we
//
// one input transaction per cycle while in_stall is low; a result shows on out
// from the result register, after waiting in the skid register if out stalls.
// in_stall rises only when both result and skid registers are occupied.
// reset (rst, synchronous) clears phase, counters and buffer, and loads
// the register defaults (100 periods, 5000000 ticks timeout).
module multi_period_meter #(
  parameter int COUNTER_WIDTH = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  mpm_pkg::in_t                    in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output mpm_pkg::out_t                   out_data,
  input  logic                            cfg_we,
  input  logic [mpm_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [mpm_pkg::CFG_DATA_W-1:0]  cfg_data
);

  logic             accept;
  logic             full;
  mpm_pkg::result_t result;

  assign in_stall = full;
  assign accept   = in_valid && !full;

  // measurement logic
  mpm_core #(
    .COUNTER_WIDTH(COUNTER_WIDTH)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .in_data  (in_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .result   (result)
  );

  // result register and skid stage
  mpm_out_buf u_out_buf (
    .clk      (clk),
    .rst      (rst),
    .result   (result),
    .full     (full),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

endmodule

// ----- tb/tb_multi_period_meter.sv -----
// self-checking testbench for multi_period_meter: directed table, then random
// square-wave measurements checked against a behavioral predictor
// depends on mpm_pkg and multi_period_meter
module tb_multi_period_meter;

  localparam logic [31:0] COUNT_MAX    = 32'hFFFF_FFFF;
  localparam int          SETTLE_WAIT  = 4;
  localparam int          END_WAIT     = 12;
  localparam int          LIVE_TARGET  = 1120;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int          REPORT_LIMIT = 10;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t                       kind;
    mpm_pkg::in_t                    item;
    logic [mpm_pkg::CFG_INDEX_W-1:0] reg_index;
    logic [mpm_pkg::CFG_DATA_W-1:0]  reg_data;
    bit                              typed;
    bit                              has_res;
    mpm_pkg::out_t                   res;
  } row_t;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            in_valid = 1'b0;
  logic                            in_stall;
  mpm_pkg::in_t                    in_data = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  mpm_pkg::out_t                   out_data;
  logic                            cfg_we = 1'b0;
  logic [mpm_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [mpm_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

  // predicted meter state and register copies
  mpm_pkg::phase_t meter_phase = mpm_pkg::PH_IDLE;
  logic [31:0]     tick_cnt = '0;
  logic [15:0]     periods_done = '0;
  logic [15:0]     cfg_periods = mpm_pkg::PERIODS_RESET;
  logic [31:0]     cfg_timeout = mpm_pkg::TIMEOUT_RESET;

  mpm_pkg::out_t pending_results[$];
  row_t          directed_rows[$];
  int            mismatches = 0;
  int            live_items = 0;
  int unsigned   cycle_count = 0;
  bit            tx_quiet = 1'b0;
  bit            rx_quiet = 1'b0;
  mpm_pkg::out_t oldest_result;

  multi_period_meter i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // one tick or start through the meter, returns 1 when a result comes out
  function automatic bit meter_step(input mpm_pkg::in_t item, output mpm_pkg::out_t res);
    logic want;
    res = '0;
    if (item.func == mpm_pkg::FUNC_START) begin
      tick_cnt     = '0;
      periods_done = '0;
      if (cfg_periods == 16'd0) begin
        meter_phase = mpm_pkg::PH_IDLE;
        return 1'b1;
      end
      meter_phase = mpm_pkg::PH_PRE_LOW;
      return 1'b0;
    end
    if (meter_phase == mpm_pkg::PH_IDLE) return 1'b0;
    if (tick_cnt != COUNT_MAX) tick_cnt = tick_cnt + 32'd1;
    want = (meter_phase == mpm_pkg::PH_PRE_HIGH) || (meter_phase == mpm_pkg::PH_MEAS_HIGH);
    if (item.pin_level == want) begin
      case (meter_phase)
        mpm_pkg::PH_PRE_LOW: begin
          meter_phase = mpm_pkg::PH_PRE_HIGH;
          tick_cnt    = '0;
        end
        mpm_pkg::PH_PRE_HIGH: begin
          meter_phase = mpm_pkg::PH_MEAS_LOW;
          tick_cnt    = '0;
        end
        mpm_pkg::PH_MEAS_LOW: meter_phase = mpm_pkg::PH_MEAS_HIGH;
        default: begin
          if (periods_done != 16'hFFFF) periods_done = periods_done + 16'd1;
          if (periods_done >= cfg_periods) begin
            res.period_count = tick_cnt;
            meter_phase      = mpm_pkg::PH_IDLE;
            return 1'b1;
          end
          meter_phase = mpm_pkg::PH_MEAS_LOW;
        end
      endcase
      return 1'b0;
    end
    // waiting too long, or counter pinned at its maximum
    if (tick_cnt > cfg_timeout || tick_cnt == COUNT_MAX) begin
      res.no_signal = 1'b1;
      meter_phase   = mpm_pkg::PH_IDLE;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic mpm_pkg::in_t make_item(input logic func, input logic pin);
    mpm_pkg::in_t item;
    item.func      = func;
    item.pin_level = pin;
    return item;
  endfunction

  // drive one input transaction and hold it until accepted
  task automatic send_item(input mpm_pkg::in_t item);
    int gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // send, predict, and queue the expected result
  task automatic issue(input mpm_pkg::in_t item, input bit typed, input bit has_res,
                       input mpm_pkg::out_t typed_res);
    mpm_pkg::out_t res;
    bit            got;
    bit            live;
    send_item(item);
    live = (item.func == mpm_pkg::FUNC_START) || (meter_phase != mpm_pkg::PH_IDLE);
    got  = meter_step(item, res);
    if (typed) begin
      got = has_res;
      res = typed_res;
    end
    if (live) live_items++;
    if (got) pending_results.push_back(res);
  endtask

  // stop sending and let every outstanding result drain
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(input logic [mpm_pkg::CFG_INDEX_W-1:0] index,
                           input logic [mpm_pkg::CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (index == mpm_pkg::REG_PERIODS) cfg_periods = data[15:0];
    else cfg_timeout = data;
  endtask

  // clear every field of a table row
  function automatic row_t blank_row();
    row_t r;
    r.kind      = ROW_ITEM;
    r.item      = '0;
    r.reg_index = '0;
    r.reg_data  = '0;
    r.typed     = 1'b0;
    r.has_res   = 1'b0;
    r.res       = '0;
    return r;
  endfunction

  task automatic add_item(input logic func, input logic pin);
    row_t r;
    r         = blank_row();
    r.kind    = ROW_ITEM;
    r.item    = make_item(func, pin);
    directed_rows.push_back(r);
  endtask

  task automatic add_expect(input logic func, input logic pin, input bit has_res,
                            input logic [31:0] count, input logic flag);
    row_t r;
    r                  = blank_row();
    r.kind             = ROW_ITEM;
    r.item             = make_item(func, pin);
    r.typed            = 1'b1;
    r.has_res          = has_res;
    r.res.period_count = count;
    r.res.no_signal    = flag;
    directed_rows.push_back(r);
  endtask

  task automatic add_cfg(input logic [mpm_pkg::CFG_INDEX_W-1:0] index,
                         input logic [mpm_pkg::CFG_DATA_W-1:0] data);
    row_t r;
    r           = blank_row();
    r.kind      = ROW_CFG;
    r.reg_index = index;
    r.reg_data  = data;
    directed_rows.push_back(r);
  endtask

  // result side: random stall before each transaction
  initial begin : result_sink
    int gap;
    @(negedge rst);
    forever begin
      gap = rx_quiet ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected result: period_count %0d no_signal %0b",
                   out_data.period_count, out_data.no_signal);
      end else begin
        oldest_result = pending_results.pop_front();
        if (out_data.period_count !== oldest_result.period_count ||
            out_data.no_signal !== oldest_result.no_signal) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("mismatch: period_count exp %0d got %0d, no_signal exp %0b got %0b",
                     oldest_result.period_count, out_data.period_count,
                     oldest_result.no_signal, out_data.no_signal);
        end
      end
    end
  end

  initial begin : stimulus
    row_t        r;
    logic [31:0] data;
    logic        lvl;
    logic        noise_func;
    int          run;
    int          seq_len;
    int          seq_cap;
    int          phase_end;
    int          burst;

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: idle tick, zero periods, a one-tick timeout, restart while busy,
    // maximum periods with a near-maximum timeout and a register change mid-measurement
    add_expect(mpm_pkg::FUNC_TICK, 1'b1, 1'b0, 32'd0, 1'b0);
    add_cfg(mpm_pkg::REG_PERIODS, 32'd0);
    add_expect(mpm_pkg::FUNC_START, 1'b0, 1'b1, 32'd0, 1'b0);
    add_cfg(mpm_pkg::REG_PERIODS, 32'd1);
    add_cfg(mpm_pkg::REG_TIMEOUT, 32'd1);
    add_item(mpm_pkg::FUNC_START, 1'b1);
    add_item(mpm_pkg::FUNC_TICK, 1'b1);
    add_expect(mpm_pkg::FUNC_TICK, 1'b1, 1'b1, 32'd0, 1'b1);
    add_item(mpm_pkg::FUNC_START, 1'b0);
    add_item(mpm_pkg::FUNC_TICK, 1'b0);
    add_item(mpm_pkg::FUNC_TICK, 1'b1);
    add_item(mpm_pkg::FUNC_TICK, 1'b0);
    add_item(mpm_pkg::FUNC_TICK, 1'b1);
    add_item(mpm_pkg::FUNC_START, 1'b0);
    add_item(mpm_pkg::FUNC_TICK, 1'b0);
    add_item(mpm_pkg::FUNC_START, 1'b1);
    add_item(mpm_pkg::FUNC_TICK, 1'b0);
    add_item(mpm_pkg::FUNC_TICK, 1'b1);
    add_item(mpm_pkg::FUNC_TICK, 1'b0);
    add_item(mpm_pkg::FUNC_TICK, 1'b1);
    add_cfg(mpm_pkg::REG_TIMEOUT, 32'hFFFF_FFFE);
    add_cfg(mpm_pkg::REG_PERIODS, 32'hFFFF_FFFF);
    add_item(mpm_pkg::FUNC_START, 1'b0);
    add_item(mpm_pkg::FUNC_TICK, 1'b0);
    add_item(mpm_pkg::FUNC_TICK, 1'b1);
    add_item(mpm_pkg::FUNC_TICK, 1'b0);
    add_item(mpm_pkg::FUNC_TICK, 1'b1);
    add_cfg(mpm_pkg::REG_PERIODS, 32'd1);
    add_item(mpm_pkg::FUNC_TICK, 1'b0);
    add_item(mpm_pkg::FUNC_TICK, 1'b1);

    foreach (directed_rows[i]) begin
      r = directed_rows[i];
      if (r.kind == ROW_CFG) begin
        settle();
        write_reg(r.reg_index, r.reg_data);
      end else begin
        issue(r.item, r.typed, r.has_res, r.res);
      end
    end

    // random: phases of fixed settings, mostly square waves
    while (live_items < LIVE_TARGET) begin
      settle();
      data = $urandom();
      case ($urandom_range(0, 9))
        0:       data[15:0] = 16'd0;
        1:       data[15:0] = 16'hFFFF;
        2, 3:    data[15:0] = 16'd1;
        default: data[15:0] = 16'($urandom_range(2, 6));
      endcase
      write_reg(mpm_pkg::REG_PERIODS, data);
      case ($urandom_range(0, 7))
        0:       data = 32'd1;
        1:       data = 32'hFFFF_FFFE;
        2:       data = 32'd2;
        default: data = 32'($urandom_range(6, 60));
      endcase
      write_reg(mpm_pkg::REG_TIMEOUT, data);
      tx_quiet  = ($urandom_range(0, 3) == 0);
      rx_quiet  = ($urandom_range(0, 3) == 0);
      phase_end = live_items + $urandom_range(60, 140);

      while (live_items < phase_end) begin
        if ($urandom_range(0, 9) == 0) begin
          // noise
          burst = $urandom_range(1, 6);
          repeat (burst) begin
            noise_func = ($urandom_range(0, 5) == 0) ? mpm_pkg::FUNC_START
                                                      : mpm_pkg::FUNC_TICK;
            issue(make_item(noise_func, 1'($urandom_range(0, 1))), 1'b0, 1'b0, '0);
          end
        end else begin
          // start, then a square wave; sometimes cut short
          issue(make_item(mpm_pkg::FUNC_START, 1'($urandom_range(0, 1))), 1'b0, 1'b0, '0);
          lvl     = 1'($urandom_range(0, 1));
          seq_len = 0;
          seq_cap = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 10) : 80;
          while (meter_phase != mpm_pkg::PH_IDLE && seq_len < seq_cap) begin
            run = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 40) : $urandom_range(1, 4);
            for (int k = 0;
                 k < run && meter_phase != mpm_pkg::PH_IDLE && seq_len < seq_cap;
                 k++) begin
              issue(make_item(mpm_pkg::FUNC_TICK, lvl), 1'b0, 1'b0, '0);
              seq_len++;
            end
            lvl = ~lvl;
          end
        end
      end
    end

    // drain and let any late result show
    settle();
    repeat (END_WAIT) @(posedge clk);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
